[rtl/srp_pkg.sv]
// Shared types and constants for the status report parser.
package srp_pkg;

  typedef enum logic [3:0] {
    PH_ADMIN    = 4'd0,
    PH_STATUS   = 4'd1,
    PH_REASON   = 4'd2,
    PH_FRAGOFF  = 4'd3,
    PH_FRAGLEN  = 4'd4,
    PH_STAMP    = 4'd5,
    PH_EIDLEN   = 4'd6,
    PH_EIDBYTES = 4'd7,
    PH_TAIL     = 4'd8
  } phase_t;

  localparam logic [3:0] KIND_ADMFLAGS = 4'd0;
  localparam logic [3:0] KIND_STATUS   = 4'd1;
  localparam logic [3:0] KIND_REASON   = 4'd2;
  localparam logic [3:0] KIND_FRAGOFF  = 4'd3;
  localparam logic [3:0] KIND_FRAGLEN  = 4'd4;
  localparam logic [3:0] KIND_TSEC     = 4'd5;
  localparam logic [3:0] KIND_TSEQ     = 4'd6;
  localparam logic [3:0] KIND_EIDLEN   = 4'd7;
  localparam logic [3:0] KIND_EIDBYTE  = 4'd8;
  localparam logic [3:0] KIND_END      = 4'd9;

  localparam logic [2:0] ERR_OK        = 3'd0;
  localparam logic [2:0] ERR_BAD_TYPE  = 3'd1;
  localparam logic [2:0] ERR_TRUNC     = 3'd2;
  localparam logic [2:0] ERR_SDNV      = 3'd3;
  localparam logic [2:0] ERR_EID       = 3'd4;
  localparam logic [2:0] ERR_OVERSIZE  = 3'd5;

  localparam logic [1:0] REG_ADMIN_TYPE = 2'd0;
  localparam logic [1:0] REG_FRAG_MASK  = 2'd1;
  localparam logic [1:0] REG_MAX_BYTES  = 2'd2;

  localparam logic [2:0]  CREATION_SLOT = 3'd6;
  localparam logic [14:0] EID_MAX       = 15'h7fff;
  localparam logic [14:0] MAX_BYTES_RST = 15'd16384;

  // Up to two results per byte: an optional field, then an optional end.
  typedef struct packed {
    logic        fld_vld;
    logic [3:0]  kind;
    logic [2:0]  slot;
    logic [63:0] value;
    logic        end_vld;
    logic [2:0]  err;
  } entry_t;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

endpackage

[rtl/status_report_parser_top.sv]
// Top level of the status report parser.
// Input channel: in_valid/in_stall with payload_byte and is_last; one byte
// per transaction, is_last on the final byte of a record.
// Output channel: out_valid/out_stall with field_kind, stamp_slot,
// field_value, error_code and record_done; one result per transaction.
// The front end parses a byte in the cycle it is accepted and writes an
// entry of up to two results (a field and an end result) into a four-entry
// queue, where it is registered; the back end presents them one per cycle
// while out_stall is low. A byte is taken every cycle while the queue has
// room, so the rate is one byte per cycle, limited only by the output side;
// a byte that completes a field and ends a record yields two results.
// Configuration: cfg_we, cfg_index, cfg_data; write only when idle.
// Reset (rst, synchronous) empties the queue, restarts parsing at the
// admin byte and restores the register defaults.
// When out_stall is high the queue fills and in_stall rises.
module status_report_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  payload_byte,
  input  logic        is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  field_kind,
  output logic [2:0]  stamp_slot,
  output logic [63:0] field_value,
  output logic [2:0]  error_code,
  output logic        record_done,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  logic [3:0]  exp_type, frag_mask;
  logic [14:0] max_bytes;
  logic        room, ent_vld, in_ok;
  srp_pkg::entry_t ent;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_type  <= 4'd1;
      frag_mask <= 4'd1;
      max_bytes <= srp_pkg::MAX_BYTES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        srp_pkg::REG_ADMIN_TYPE: exp_type  <= cfg_data[3:0];
        srp_pkg::REG_FRAG_MASK:  frag_mask <= cfg_data[3:0];
        srp_pkg::REG_MAX_BYTES:  max_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = !room;
  assign in_ok    = in_valid && room;

  srp_front u_front (
    .clk(clk), .rst(rst), .in_ok(in_ok), .byte_in(payload_byte),
    .last_in(is_last), .exp_type(exp_type), .frag_mask(frag_mask),
    .max_bytes(max_bytes), .ent_vld(ent_vld), .ent(ent)
  );

  srp_back u_back (
    .clk(clk), .rst(rst), .ent_vld(ent_vld), .ent(ent), .room(room),
    .valid(out_valid), .stall(out_stall), .field_kind(field_kind),
    .stamp_slot(stamp_slot), .field_value(field_value),
    .error_code(error_code), .record_done(record_done)
  );

endmodule

[rtl/srp_front.sv]
// Front end: parses each byte and produces an entry of up to two results.
module srp_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_ok,
  input  logic [7:0]           byte_in,
  input  logic                 last_in,
  input  logic [3:0]           exp_type,
  input  logic [3:0]           frag_mask,
  input  logic [14:0]          max_bytes,
  output logic                 ent_vld,
  output srp_pkg::entry_t      ent
);

  localparam logic [2:0] CREATION_SLOT_F = srp_pkg::CREATION_SLOT;

  srp_pkg::phase_t phase, phase_next;
  logic [63:0] acc, acc_next;
  logic [3:0]  cnt, cnt_next;
  logic [2:0]  slot, slot_next;
  logic        half, half_next;
  logic [7:0]  sflags, sflags_next;
  logic [3:0]  aflags, aflags_next;
  logic [14:0] eid_rem, eid_rem_next;
  logic [14:0] rcount, rcount_next;
  logic        skipping, skipping_next;

  logic [63:0] shifted;
  logic [2:0]  err;
  logic [2:0]  stamp_from;
  logic        stamp_go;
  logic [2:0]  stamp_slot;
  logic        sdnv_ovf;
  logic        sdnv_done;
  logic        newrec;

  // first present slot at or after stamp_from among slots 0-5, else the creation slot
  always_comb begin
    stamp_slot = CREATION_SLOT_F;
    for (int i = 5; i >= 0; i--) begin
      if (i[2:0] >= stamp_from && sflags[i]) stamp_slot = i[2:0];
    end
  end

  always_comb begin
    phase_next    = phase;
    acc_next      = acc;
    cnt_next      = cnt;
    slot_next     = slot;
    half_next     = half;
    sflags_next   = sflags;
    aflags_next   = aflags;
    eid_rem_next  = eid_rem;
    rcount_next   = rcount;
    skipping_next = skipping;
    ent_vld       = 1'b0;
    ent           = '0;
    err           = srp_pkg::ERR_OK;
    stamp_from    = 3'd0;
    stamp_go      = 1'b0;
    newrec        = 1'b0;
    sdnv_ovf      = (cnt >= 4'd10) || (cnt == 4'd9 && acc[63:56] != 8'd1);
    shifted       = {acc[56:0], byte_in[6:0]};
    sdnv_done     = !byte_in[7];

    if (in_ok) begin
      if (skipping) begin
        if (last_in) begin
          skipping_next = 1'b0;
          newrec        = 1'b1;
        end
      end else begin
        if (rcount >= max_bytes) begin
          err = srp_pkg::ERR_OVERSIZE;
        end else begin
          rcount_next = rcount + 15'd1;
          case (phase)
            srp_pkg::PH_ADMIN: begin
              ent.fld_vld = 1'b1;
              ent.kind    = srp_pkg::KIND_ADMFLAGS;
              ent.value   = {56'd0, byte_in};
              aflags_next = byte_in[3:0];
              if (byte_in[7:4] != exp_type) err = srp_pkg::ERR_BAD_TYPE;
              else phase_next = srp_pkg::PH_STATUS;
            end
            srp_pkg::PH_STATUS: begin
              ent.fld_vld = 1'b1;
              ent.kind    = srp_pkg::KIND_STATUS;
              ent.value   = {56'd0, byte_in};
              sflags_next = byte_in;
              phase_next  = srp_pkg::PH_REASON;
            end
            srp_pkg::PH_REASON: begin
              ent.fld_vld = 1'b1;
              ent.kind    = srp_pkg::KIND_REASON;
              ent.value   = {56'd0, byte_in};
              if ((aflags & frag_mask) != 4'd0) phase_next = srp_pkg::PH_FRAGOFF;
              else stamp_go = 1'b1;
            end
            srp_pkg::PH_FRAGOFF, srp_pkg::PH_FRAGLEN,
            srp_pkg::PH_STAMP, srp_pkg::PH_EIDLEN: begin
              if (sdnv_ovf) begin
                err = srp_pkg::ERR_SDNV;
              end else if (!sdnv_done) begin
                acc_next = shifted;
                cnt_next = cnt + 4'd1;
              end else begin
                acc_next    = '0;
                cnt_next    = '0;
                ent.fld_vld = 1'b1;
                ent.value   = shifted;
                case (phase)
                  srp_pkg::PH_FRAGOFF: begin
                    ent.kind   = srp_pkg::KIND_FRAGOFF;
                    phase_next = srp_pkg::PH_FRAGLEN;
                  end
                  srp_pkg::PH_FRAGLEN: begin
                    ent.kind = srp_pkg::KIND_FRAGLEN;
                    stamp_go = 1'b1;
                  end
                  srp_pkg::PH_STAMP: begin
                    ent.kind = half ? srp_pkg::KIND_TSEQ : srp_pkg::KIND_TSEC;
                    ent.slot = slot;
                    if (!half) begin
                      half_next = 1'b1;
                    end else if (slot >= srp_pkg::CREATION_SLOT) begin
                      half_next  = 1'b0;
                      phase_next = srp_pkg::PH_EIDLEN;
                    end else begin
                      stamp_go   = 1'b1;
                      stamp_from = slot + 3'd1;
                    end
                  end
                  default: begin
                    ent.kind = srp_pkg::KIND_EIDLEN;
                    if (shifted > {49'd0, srp_pkg::EID_MAX}) begin
                      err = srp_pkg::ERR_EID;
                    end else begin
                      eid_rem_next = shifted[14:0];
                      phase_next   = (shifted[14:0] != 15'd0) ? srp_pkg::PH_EIDBYTES
                                                              : srp_pkg::PH_TAIL;
                    end
                  end
                endcase
              end
            end
            srp_pkg::PH_EIDBYTES: begin
              ent.fld_vld  = 1'b1;
              ent.kind     = srp_pkg::KIND_EIDBYTE;
              ent.value    = {56'd0, byte_in};
              eid_rem_next = eid_rem - 15'd1;
              if (eid_rem == 15'd1) phase_next = srp_pkg::PH_TAIL;
            end
            default: err = srp_pkg::ERR_EID;
          endcase
          if (stamp_go) begin
            slot_next  = stamp_slot;
            half_next  = 1'b0;
            phase_next = srp_pkg::PH_STAMP;
          end
        end

        if (err != srp_pkg::ERR_OK) begin
          ent.end_vld = 1'b1;
          ent.err     = err;
          if (last_in) newrec = 1'b1;
          else skipping_next = 1'b1;
        end else if (last_in) begin
          ent.end_vld = 1'b1;
          if (phase_next == srp_pkg::PH_TAIL) ent.err = srp_pkg::ERR_OK;
          else if (phase_next == srp_pkg::PH_EIDBYTES) ent.err = srp_pkg::ERR_EID;
          else ent.err = srp_pkg::ERR_TRUNC;
          newrec = 1'b1;
        end
        ent_vld = ent.fld_vld || ent.end_vld;
      end

      if (newrec) begin
        phase_next   = srp_pkg::PH_ADMIN;
        acc_next     = '0;
        cnt_next     = '0;
        slot_next    = '0;
        half_next    = 1'b0;
        sflags_next  = '0;
        aflags_next  = '0;
        eid_rem_next = '0;
        rcount_next  = '0;
      end
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= srp_pkg::PH_ADMIN;
      acc      <= '0;
      cnt      <= '0;
      slot     <= '0;
      half     <= 1'b0;
      sflags   <= '0;
      aflags   <= '0;
      eid_rem  <= '0;
      rcount   <= '0;
      skipping <= 1'b0;
    end else begin
      phase    <= phase_next;
      acc      <= acc_next;
      cnt      <= cnt_next;
      slot     <= slot_next;
      half     <= half_next;
      sflags   <= sflags_next;
      aflags   <= aflags_next;
      eid_rem  <= eid_rem_next;
      rcount   <= rcount_next;
      skipping <= skipping_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt <= 4'd10)
    else $error("sdnv byte count out of range");
  a_skip_no_ent: assert property (@(posedge clk) disable iff (rst)
    skipping |-> !ent_vld)
    else $error("entry produced while skipping");
  a_err_end: assert property (@(posedge clk) disable iff (rst)
    (ent_vld && ent.err != srp_pkg::ERR_OK) |-> ent.end_vld)
    else $error("error without end result");
`endif

endmodule

[rtl/srp_back.sv]
// Back end: queue of parsed entries, expanded into single result transactions.
module srp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            ent_vld,
  input  srp_pkg::entry_t ent,
  output logic            room,
  output logic            valid,
  input  logic            stall,
  output logic [3:0]      field_kind,
  output logic [2:0]      stamp_slot,
  output logic [63:0]     field_value,
  output logic [2:0]      error_code,
  output logic            record_done
);

  srp_pkg::entry_t q [srp_pkg::QDEPTH];
  logic [srp_pkg::QAW-1:0] wp, rp;
  logic [srp_pkg::QAW:0]   fill;
  logic                    fld_sent;
  srp_pkg::entry_t         head;
  logic                    head_vld, take, pop, push;

  assign head     = q[rp];
  assign head_vld = (fill != '0);
  // room while fewer than QDEPTH-1 entries are held, so one slot stays free
  assign room     = (fill < (srp_pkg::QAW+1)'(srp_pkg::QDEPTH - 1));
  assign push     = ent_vld;

  // present field first, then end result
  always_comb begin
    valid       = head_vld;
    field_kind  = head.kind;
    stamp_slot  = head.slot;
    field_value = head.value;
    error_code  = srp_pkg::ERR_OK;
    record_done = 1'b0;
    if (!head.fld_vld || fld_sent) begin
      field_kind  = srp_pkg::KIND_END;
      stamp_slot  = '0;
      field_value = '0;
      error_code  = head.err;
      record_done = 1'b1;
    end
  end

  assign take = valid && !stall;
  assign pop  = take && (record_done || !head.end_vld);

  always_ff @(posedge clk) begin
    if (push) q[wp] <= ent;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      rp       <= '0;
      fill     <= '0;
      fld_sent <= 1'b0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      fill <= fill + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
      if (pop) fld_sent <= 1'b0;
      else if (take) fld_sent <= 1'b1;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fill <= (srp_pkg::QAW+1)'(srp_pkg::QDEPTH))
    else $error("queue overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> fill != (srp_pkg::QAW+1)'(srp_pkg::QDEPTH))
    else $error("push into full queue");
  a_sent_has_head: assert property (@(posedge clk) disable iff (rst)
    fld_sent |-> head_vld)
    else $error("field marked sent with empty queue");
`endif

endmodule
